// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the bit packer RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, quiet while reset is asserted.
`define LSBP_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
	else $error("lsbp assertion failed");

// Check that a condition never holds.
`define LSBP_ASSERT_NEVER(lbl, clk, rstn, cond) \
	`LSBP_ASSERT(lbl, clk, rstn, !(cond))

`endif

// ===== rtl/lsbp_pkg.sv =====
// Shared types and constants of the LSB-first bit packer.
// Depends on nothing; imported by every module and the stream interface users.
package lsbp_pkg;

	localparam int MAX_CODE_WIDTH_DEF = 32;
	localparam int CODE_W             = 32;
	localparam int WIDTH_W            = 6;
	localparam int BYTE_W             = 8;
	// Result count of one job; covers every legal code width limit.
	localparam int ITEM_CNT_W         = 4;

	typedef enum logic [1:0] {
		JOB_BYTES,
		JOB_EMPTY,
		JOB_BAD
	} job_kind_t;

	typedef struct packed {
		job_kind_t              kind;
		logic [ITEM_CNT_W-1:0]  items;
	} job_ctrl_t;

	typedef struct packed {
		logic               cmd;
		logic [CODE_W-1:0]  code;
		logic [WIDTH_W-1:0] width;
	} in_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              byte_valid;
		logic              bad_width;
		logic              last;
	} out_item_t;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

endpackage

// ===== rtl/lsbp_stream_if.sv =====
// Valid/ready stream channel carrying one payload of a given type.
// Depends on nothing; payload types come from lsbp_pkg at the instance.
interface lsbp_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/lsbp_front.sv =====
// Front end: accepts commands, keeps the held bits and builds one job per transaction.
// Depends on lsbp_pkg and lsbp_stream_if.
module lsbp_front
	import lsbp_pkg::*;
#(
	parameter int MAX_CODE_WIDTH = MAX_CODE_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	lsbp_stream_if.sink                    req,
	output logic                           push_valid,
	input  logic                           push_ready,
	output job_ctrl_t                      push_ctrl,
	output logic [MAX_CODE_WIDTH+6:0]      push_data
);
	localparam int BUF_W  = MAX_CODE_WIDTH + 7;
	localparam int WIDE_W = BUF_W + CODE_W;
	localparam int CNT_W  = $clog2(BUF_W + 1);
	localparam logic [WIDTH_W:0] MAX_W = (WIDTH_W + 1)'(MAX_CODE_WIDTH);

	logic [6:0]          held_bits_q;
	logic [2:0]          held_count_q;
	logic [CODE_W-1:0]   code_m;
	logic [WIDE_W-1:0]   code_sh;
	logic [BUF_W-1:0]    buf_w;
	logic [BUF_W-1:0]    buf_rest;
	logic [CNT_W-1:0]    count;
	logic [CNT_W-4:0]    nbytes;
	logic                width_bad;
	logic                accept;
	logic [6:0]          held_bits_d;
	logic [2:0]          held_count_d;

	assign push_valid = req.valid;
	assign req.ready  = push_ready;
	assign accept     = req.valid && push_ready;

	// Drop code bits at and above the width
	always_comb begin
		for (int i = 0; i < CODE_W; i++) begin
			code_m[i] = req.data.code[i] && (WIDTH_W'(i) < req.data.width);
		end
	end

	// Append the code above the held bits
	assign code_sh   = WIDE_W'(code_m) << held_count_q;
	assign buf_w     = code_sh[BUF_W-1:0] | BUF_W'(held_bits_q);
	assign count     = CNT_W'(held_count_q) + CNT_W'(req.data.width);
	assign nbytes    = count[CNT_W-1:3];
	assign buf_rest  = buf_w >> {count[CNT_W-1:3], 3'b000};
	assign width_bad = (req.data.width == '0) || ({1'b0, req.data.width} > MAX_W);

	// Classify the transaction and work out the next held state
	always_comb begin
		push_ctrl.kind  = JOB_EMPTY;
		push_ctrl.items = ITEM_CNT_W'(1);
		push_data       = '0;
		held_bits_d     = held_bits_q;
		held_count_d    = held_count_q;
		if (req.data.cmd == CMD_FLUSH) begin
			if (held_count_q != '0) begin
				push_ctrl.kind = JOB_BYTES;
				push_data      = BUF_W'(held_bits_q);
				held_bits_d    = '0;
				held_count_d   = '0;
			end
		end else if (width_bad) begin
			push_ctrl.kind = JOB_BAD;
		end else begin
			push_data    = buf_w;
			held_bits_d  = buf_rest[6:0];
			held_count_d = count[2:0];
			if (nbytes != '0) begin
				push_ctrl.kind  = JOB_BYTES;
				push_ctrl.items = ITEM_CNT_W'(nbytes);
			end
		end
	end

	// Update the held bits on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_bits_q  <= '0;
			held_count_q <= '0;
		end else if (accept) begin
			held_bits_q  <= held_bits_d;
			held_count_q <= held_count_d;
		end
	end

endmodule

// ===== rtl/lsbp_queue.sv =====
// Two-entry job queue between the front and back ends.
// Depends on lsbp_pkg for the job control type.
module lsbp_queue
	import lsbp_pkg::*;
#(
	parameter int DATA_W = MAX_CODE_WIDTH_DEF + 7
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  job_ctrl_t         push_ctrl,
	input  logic [DATA_W-1:0] push_data,
	output logic              pop_valid,
	input  logic              pop_ready,
	output job_ctrl_t         pop_ctrl,
	output logic [DATA_W-1:0] pop_data
);
	localparam int DEPTH = 2;

	job_ctrl_t         ctrl_q [DEPTH];
	logic [DATA_W-1:0] data_q [DEPTH];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        cnt_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (cnt_q != 2'(DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_ctrl   = ctrl_q[rd_ptr_q];
	assign pop_data   = data_q[rd_ptr_q];

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop)  rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

	// Store the pushed job
	always_ff @(posedge clk) begin
		if (do_push) begin
			ctrl_q[wr_ptr_q] <= push_ctrl;
			data_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== rtl/lsbp_back.sv =====
// Back end: walks one job at a time and emits its result items, one per cycle while rsp does not stall them.
// Depends on lsbp_pkg and lsbp_stream_if.
module lsbp_back
	import lsbp_pkg::*;
#(
	parameter int DATA_W = MAX_CODE_WIDTH_DEF + 7
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pop_valid,
	output logic              pop_ready,
	input  job_ctrl_t         pop_ctrl,
	input  logic [DATA_W-1:0] pop_data,
	lsbp_stream_if.source     rsp
);
	logic                  cur_valid_q;
	job_kind_t             cur_kind_q;
	logic [ITEM_CNT_W-1:0] cur_left_q;
	logic [DATA_W-1:0]     cur_data_q;
	logic                  out_valid_q;
	out_item_t             out_item_q;
	out_item_t             item;
	logic                  produce;
	logic                  finish;

	assign produce   = cur_valid_q && (!out_valid_q || rsp.ready);
	assign finish    = produce && (cur_left_q == ITEM_CNT_W'(1));
	assign pop_ready = !cur_valid_q || finish;

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_item_q;

	// Build the next result item from the current job
	always_comb begin
		item.out_byte   = '0;
		item.byte_valid = 1'b0;
		item.bad_width  = 1'b0;
		item.last       = (cur_left_q == ITEM_CNT_W'(1));
		case (cur_kind_q)
			JOB_BYTES: begin
				item.out_byte   = cur_data_q[BYTE_W-1:0];
				item.byte_valid = 1'b1;
			end
			JOB_BAD: begin
				item.bad_width = 1'b1;
			end
			default: begin
				item.out_byte = '0;
			end
		endcase
	end

	// Load a job, or advance the current one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop_valid && pop_ready) begin
				cur_valid_q <= 1'b1;
			end else if (finish) begin
				cur_valid_q <= 1'b0;
			end
			if (produce) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hold job payload and the output register
	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready) begin
			cur_kind_q <= pop_ctrl.kind;
			cur_left_q <= pop_ctrl.items;
			cur_data_q <= pop_data;
		end else if (produce) begin
			cur_left_q <= cur_left_q - ITEM_CNT_W'(1);
			cur_data_q <= cur_data_q >> BYTE_W;
		end
		if (produce) begin
			out_item_q <= item;
		end
	end

endmodule

// ===== rtl/lsb_first_bit_packer.sv =====
// LSB-first bit packer: codes of 1 to MAX_CODE_WIDTH bits go in on req, bytes come out
// on rsp, lowest bits first. A command is accepted whenever the two-entry job queue
// has room; its results leave the output register one per cycle while rsp does not stall
// them, and a command gives max(1, bytes completed) results, at most (7 + MAX_CODE_WIDTH) / 8
// (four at the default width limit). Every command gives at least one result and the
// final one carries last. Bad widths return one item with bad_width set and change
// nothing; a flush pads the held bits with zeros. Depends on lsbp_pkg, lsbp_stream_if.
`include "assert_macros.svh"

module lsb_first_bit_packer
	import lsbp_pkg::*;
#(
	parameter int MAX_CODE_WIDTH = MAX_CODE_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	lsbp_stream_if.sink   req,
	lsbp_stream_if.source rsp
);
	localparam int BUF_W = MAX_CODE_WIDTH + 7;

	logic             push_valid;
	logic             push_ready;
	job_ctrl_t        push_ctrl;
	logic [BUF_W-1:0] push_data;
	logic             pop_valid;
	logic             pop_ready;
	job_ctrl_t        pop_ctrl;
	logic [BUF_W-1:0] pop_data;

	lsbp_front #(
		.MAX_CODE_WIDTH (MAX_CODE_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_ctrl  (push_ctrl),
		.push_data  (push_data)
	);

	lsbp_queue #(
		.DATA_W (BUF_W)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_ctrl  (push_ctrl),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_ctrl   (pop_ctrl),
		.pop_data   (pop_data)
	);

	lsbp_back #(
		.DATA_W (BUF_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_ctrl  (pop_ctrl),
		.pop_data  (pop_data),
		.rsp       (rsp)
	);

	// An accepted command is waiting in the queue in the next cycle
	`LSBP_ASSERT(a_job_queued, clk, arst_n, (req.valid && req.ready) |=> pop_valid)
	// A rejected write yields one final item with no byte
	`LSBP_ASSERT(a_bad_alone, clk, arst_n, (rsp.valid && rsp.data.bad_width) |-> (rsp.data.last && !rsp.data.byte_valid))
	// The rest of a job follows without a gap
	`LSBP_ASSERT(a_job_gapless, clk, arst_n, (rsp.valid && rsp.ready && !rsp.data.last) |=> rsp.valid)
	// The queue is never full and empty at once
	`LSBP_ASSERT_NEVER(a_queue_state, clk, arst_n, !push_ready && !pop_valid)

endmodule
